// ===== rtl/servo_sync_write_framer_macros.svh =====
// ---------------------------------------------------------------------------
// Servo sync-write framer assertion macros
// Shared concurrent assertion forms for the framer RTL.
// ---------------------------------------------------------------------------
`ifndef SERVO_SYNC_WRITE_FRAMER_MACROS_SVH
`define SERVO_SYNC_WRITE_FRAMER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssw_pkg.sv =====
// ---------------------------------------------------------------------------
// Servo sync-write framer package
// Packet geometry, fixed packet bytes and register codes.
// ---------------------------------------------------------------------------
package ssw_pkg;

    localparam int NUM_SERVOS = 2;
    localparam int PKT_LEN    = 8 + 3 * NUM_SERVOS;
    localparam int IDX_W      = $clog2(PKT_LEN);
    localparam int SERVO_W    = $clog2(NUM_SERVOS + 1);
    localparam int PADDR_W    = 4;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] BCAST_ID  = 8'hFE;
    localparam logic [7:0] LEN_BYTE  = 8'(4 + 3 * NUM_SERVOS);
    localparam logic [7:0] DATA_LEN  = 8'd2;

    localparam logic [7:0] RST_OPCODE   = 8'd131;
    localparam logic [7:0] RST_POS_ADDR = 8'd30;
    localparam logic [7:0] RST_SPD_ADDR = 8'd32;

    // byte positions within the packet
    localparam logic [IDX_W-1:0] POS_BCAST  = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_LEN    = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_OPCODE = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_ADDR   = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_DLEN   = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_CSUM   = IDX_W'(PKT_LEN - 1);

    typedef enum logic [1:0] {
        REG_OPCODE   = 2'd0,
        REG_POS_ADDR = 2'd1,
        REG_SPD_ADDR = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_ID = 2'd0,
        PH_LO = 2'd1,
        PH_HI = 2'd2
    } phase_t;

    localparam logic CMD_SPEED = 1'b1;

endpackage

// ===== rtl/ssw_if.sv =====
// ---------------------------------------------------------------------------
// Servo sync-write framer channels
// Command channel and packet byte channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ssw_cmd_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] first_value;
    logic [15:0] second_value;

    modport source (output valid, cmd, first_value, second_value, input ready);
    modport sink   (input valid, cmd, first_value, second_value, output ready);
endinterface

interface ssw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, tx_byte, last_byte, input ready);
    modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

// ===== rtl/servo_sync_write_framer.sv =====
// ---------------------------------------------------------------------------
// Servo sync-write framer
// Turns one position or speed command into a broadcast sync-write packet,
// one byte per beat, with the checksum byte flagged as last.
// ---------------------------------------------------------------------------
//  channel   dir  payload                               beats
//  command   in   cmd, first_value, second_value       1 per packet
//  packet    out  tx_byte, last_byte                   8 + 3*NUM_SERVOS
//  apb       in   opcode, position / speed addresses   config
//
// A packet is 8 + 3*NUM_SERVOS bytes (14 by default), one byte per cycle
// while not stalled, paced by the byte counter feeding the output register.
// The next command is taken in the cycle the checksum byte loads, so packets
// run back to back. Output stalls hold the byte counter and the output beat.
// Reset clears the counter, the busy flag and the output valid; registers
// return to opcode 131, position address 30, speed address 32.
// ---------------------------------------------------------------------------
module servo_sync_write_framer (
    input  logic                       clk,
    input  logic                       rst_n,
    ssw_cmd_if.sink                    command,
    ssw_byte_if.source                 packet,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ssw_pkg::*;

    logic [7:0]         opcode_reg;
    logic [7:0]         pos_addr_reg;
    logic [7:0]         spd_addr_reg;

    logic               sending_reg;
    logic [IDX_W-1:0]   idx_reg;
    phase_t             phase_reg;
    logic [SERVO_W-1:0] servo_reg;
    logic [7:0]         sum_reg;
    logic [15:0]        held_first_reg;
    logic [15:0]        held_second_reg;
    logic [7:0]         held_addr_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    logic               cfg_write;
    cfg_reg_t           cfg_sel;
    logic               advance;
    logic               is_last;
    logic               cmd_fire;
    logic               summed;
    logic [7:0]         byte_next;
    logic [15:0]        servo_value;

    // -----------------------------------------------------------------------
    // configuration port
    // -----------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg   <= RST_OPCODE;
            pos_addr_reg <= RST_POS_ADDR;
            spd_addr_reg <= RST_SPD_ADDR;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_OPCODE:   opcode_reg   <= pwdata[7:0];
                REG_POS_ADDR: pos_addr_reg <= pwdata[7:0];
                REG_SPD_ADDR: spd_addr_reg <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_OPCODE:   prdata = {24'd0, opcode_reg};
            REG_POS_ADDR: prdata = {24'd0, pos_addr_reg};
            REG_SPD_ADDR: prdata = {24'd0, spd_addr_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // -----------------------------------------------------------------------
    // handshake
    // -----------------------------------------------------------------------
    assign advance       = sending_reg & (~out_valid_reg | packet.ready);
    assign is_last       = (idx_reg == POS_CSUM);
    assign command.ready = ~sending_reg | (advance & is_last);
    assign cmd_fire      = command.valid & command.ready;

    // -----------------------------------------------------------------------
    // byte select
    // -----------------------------------------------------------------------
    assign servo_value = (servo_reg == SERVO_W'(1)) ? held_first_reg : held_second_reg;

    always_comb
    begin
        summed = 1'b1;
        if (idx_reg < POS_BCAST)
        begin
            byte_next = SYNC_BYTE;
            summed    = 1'b0;
        end
        else if (idx_reg == POS_BCAST)
            byte_next = BCAST_ID;
        else if (idx_reg == POS_LEN)
            byte_next = LEN_BYTE;
        else if (idx_reg == POS_OPCODE)
            byte_next = opcode_reg;
        else if (idx_reg == POS_ADDR)
            byte_next = held_addr_reg;
        else if (idx_reg == POS_DLEN)
            byte_next = DATA_LEN;
        else if (is_last)
        begin
            byte_next = SYNC_BYTE - sum_reg;
            summed    = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_ID:   byte_next = 8'(servo_reg);
                PH_LO:   byte_next = servo_value[7:0];
                PH_HI:   byte_next = servo_value[15:8];
                default: byte_next = 8'd0;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // packet sequencer
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            idx_reg     <= '0;
            phase_reg   <= PH_ID;
            servo_reg   <= SERVO_W'(1);
            sum_reg     <= 8'd0;
        end
        else if (cmd_fire)
        begin
            sending_reg <= 1'b1;
            idx_reg     <= '0;
            phase_reg   <= PH_ID;
            servo_reg   <= SERVO_W'(1);
            sum_reg     <= 8'd0;
        end
        else if (advance)
        begin
            if (is_last)
                sending_reg <= 1'b0;
            idx_reg <= IDX_W'(idx_reg + 1'b1);
            if (summed)
                sum_reg <= 8'(sum_reg + byte_next);
            // step through id / low / high once the header is out
            if (idx_reg > POS_DLEN && !is_last)
            begin
                case (phase_reg)
                    PH_ID:   phase_reg <= PH_LO;
                    PH_LO:   phase_reg <= PH_HI;
                    PH_HI:
                    begin
                        phase_reg <= PH_ID;
                        servo_reg <= SERVO_W'(servo_reg + 1'b1);
                    end
                    default: phase_reg <= PH_ID;
                endcase
            end
        end
    end

    // capture the command payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            held_first_reg <= command.first_value;
            if (command.cmd == CMD_SPEED)
            begin
                held_second_reg <= {1'b0, command.first_value[15:1]};
                held_addr_reg   <= spd_addr_reg;
            end
            else
            begin
                held_second_reg <= command.second_value;
                held_addr_reg   <= pos_addr_reg;
            end
        end
    end

    // -----------------------------------------------------------------------
    // output register
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (packet.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_next;
            out_last_reg <= is_last;
        end
    end

    assign packet.valid     = out_valid_reg;
    assign packet.tx_byte   = out_byte_reg;
    assign packet.last_byte = out_last_reg;

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
`include "servo_sync_write_framer_macros.svh"

    `SSW_ASSERT_NEXT(a_start_clean, clk, rst_n, cmd_fire, sending_reg && idx_reg == '0 && sum_reg == 8'd0, "packet did not restart at byte zero")
    `SSW_ASSERT_NOW(a_ready_busy, clk, rst_n, command.ready && sending_reg, advance && is_last, "command taken before the checksum byte loaded")
    `SSW_ASSERT_NEXT(a_last_flag, clk, rst_n, advance && is_last, out_valid_reg && out_last_reg, "checksum byte not flagged as last")
    `SSW_ASSERT_NOW(a_idx_range, clk, rst_n, sending_reg, idx_reg <= POS_CSUM, "byte counter ran past the packet")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo sync-write framer testbench
// Sends position and speed commands through the command channel and checks
// every packet byte against a packet builder kept in step with the register
// writes. Runs four idling phases and changes the registers between them.
// ---------------------------------------------------------------------------
module testbench;
    import ssw_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;   // no register at this index
    localparam int RANDOM_PER_PHASE = 25;

    typedef struct {
        logic        cmd;
        logic [15:0] first_value;
        logic [15:0] second_value;
    } cmd_item_t;

    typedef struct {
        logic [7:0] tx_byte;
        logic       last_byte;
    } packet_beat_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ssw_cmd_if  cmd_ch ();
    ssw_byte_if pkt_ch ();

    servo_sync_write_framer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (cmd_ch),
        .packet  (pkt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register copies used to build the expected packets
    logic [7:0] opcode_q;
    logic [7:0] pos_addr_q;
    logic [7:0] spd_addr_q;

    cmd_item_t    cmd_backlog[$];
    packet_beat_t expected_bytes[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  cmd_fired;
    int  error_count;
    int  packets_taken;
    int  bytes_checked;
    int  config_writes;

    always #4 clk = ~clk;

    // build the whole packet for one command from the current registers
    function automatic void predict_packet(cmd_item_t c);
        logic [7:0]   body[$];
        logic [7:0]   csum;
        logic [15:0]  other;
        logic [15:0]  v;
        packet_beat_t b;
        body = {BCAST_ID, LEN_BYTE, opcode_q,
                (c.cmd == CMD_SPEED) ? spd_addr_q : pos_addr_q, DATA_LEN};
        other = (c.cmd == CMD_SPEED) ? (c.first_value >> 1) : c.second_value;
        for (int s = 1; s <= NUM_SERVOS; s++)
        begin
            v = (s == 1) ? c.first_value : other;
            body.push_back(8'(s));
            body.push_back(v[7:0]);
            body.push_back(v[15:8]);
        end
        csum = 8'd0;
        foreach (body[i])
            csum += body[i];
        b.last_byte = 1'b0;
        b.tx_byte = SYNC_BYTE;
        expected_bytes.push_back(b);
        expected_bytes.push_back(b);
        foreach (body[i])
        begin
            b.tx_byte = body[i];
            expected_bytes.push_back(b);
        end
        b.tx_byte = 8'hFF - csum;
        b.last_byte = 1'b1;
        expected_bytes.push_back(b);
    endfunction

    // command driver: present the next item once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_ch.valid || cmd_fired)
            begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_item_t c;
                    c = cmd_backlog.pop_front();
                    cmd_ch.valid        <= 1'b1;
                    cmd_ch.cmd          <= c.cmd;
                    cmd_ch.first_value  <= c.first_value;
                    cmd_ch.second_value <= c.second_value;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
            pkt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on each accepted command, check each accepted byte
    always @(posedge clk)
    begin
        cmd_fired <= rst_n && cmd_ch.valid && cmd_ch.ready;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            cmd_item_t c;
            c.cmd          = cmd_ch.cmd;
            c.first_value  = cmd_ch.first_value;
            c.second_value = cmd_ch.second_value;
            predict_packet(c);
            packets_taken++;
        end
        if (rst_n && pkt_ch.valid && pkt_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected packet beat: tx_byte %02h last_byte %0b",
                       pkt_ch.tx_byte, pkt_ch.last_byte);
                error_count++;
            end
            else
            begin
                packet_beat_t e;
                e = expected_bytes.pop_front();
                if (pkt_ch.tx_byte !== e.tx_byte)
                begin
                    $error("tx_byte mismatch: expected %02h actual %02h",
                           e.tx_byte, pkt_ch.tx_byte);
                    error_count++;
                end
                if (pkt_ch.last_byte !== e.last_byte)
                begin
                    $error("last_byte mismatch: expected %0b actual %0b",
                           e.last_byte, pkt_ch.last_byte);
                    error_count++;
                end
                bytes_checked++;
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [7:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = {24'($urandom), val};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_OPCODE:   opcode_q   = val;
            REG_POS_ADDR: pos_addr_q = val;
            REG_SPD_ADDR: spd_addr_q = val;
            default:      ;
        endcase
        config_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_registers(logic [7:0] op, logic [7:0] pa, logic [7:0] sa);
        apb_write(REG_OPCODE, op);
        apb_write(REG_POS_ADDR, pa);
        apb_write(REG_SPD_ADDR, sa);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_cmd(logic cmd, logic [15:0] a, logic [15:0] b);
        cmd_item_t c;
        c.cmd          = cmd;
        c.first_value  = a;
        c.second_value = b;
        cmd_backlog.push_back(c);
    endfunction

    // run the queued commands plus a random batch, then let everything drain
    task automatic run_phase(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (RANDOM_PER_PHASE)
            queue_cmd(1'($urandom), pick_value(), pick_value());
        while (cmd_backlog.size() > 0 || cmd_ch.valid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = 1'b0;
        cmd_ch.first_value = '0;
        cmd_ch.second_value = '0;
        pkt_ch.ready = 1'b0;
        cmd_fired = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        packets_taken = 0;
        bytes_checked = 0;
        config_writes = 0;
        opcode_q   = RST_OPCODE;
        pos_addr_q = RST_POS_ADDR;
        spd_addr_q = RST_SPD_ADDR;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, both commands, checksum wrap
        queue_cmd(1'b0, 16'h0000, 16'h0000);
        queue_cmd(1'b0, 16'hFFFF, 16'hFFFF);
        queue_cmd(1'b0, 16'hFFFF, 16'h0000);
        queue_cmd(1'b0, 16'h0000, 16'hFFFF);
        queue_cmd(1'b0, 16'h00FF, 16'hFF00);
        queue_cmd(1'b0, 16'hAAAA, 16'h5555);
        queue_cmd(1'b0, 16'h0001, 16'h8000);
        queue_cmd(1'b1, 16'h0000, 16'hFFFF);
        queue_cmd(1'b1, 16'hFFFF, 16'h1234);
        queue_cmd(1'b1, 16'h0001, 16'hFFFF);
        queue_cmd(1'b1, 16'h8000, 16'h0000);
        queue_cmd(1'b1, 16'h5555, 16'hAAAA);
        queue_cmd(1'b1, 16'hAAAA, 16'h5555);
        queue_cmd(1'b1, 16'h0002, 16'h0000);
        queue_cmd(1'b0, 16'h7F80, 16'h807F);
        queue_cmd(1'b1, 16'hFFFE, 16'hFFFF);
        run_phase(0, 0);

        // low extremes; a write past the last register must change nothing
        set_registers(8'h00, 8'h00, 8'h00);
        apb_write(REG_NONE, 8'hA5);
        queue_cmd(1'b0, 16'hFFFF, 16'hFFFF);
        queue_cmd(1'b1, 16'hFFFF, 16'hFFFF);
        run_phase(50, 0);

        set_registers(8'hFF, 8'hFF, 8'hFF);
        queue_cmd(1'b0, 16'hFFFF, 16'hFFFF);
        queue_cmd(1'b1, 16'h0000, 16'h0000);
        run_phase(0, 50);

        set_registers(8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(7, 7);

        repeat (20) @(posedge clk);
        $display("covered %0d packets (%0d bytes checked) over four idling phases",
                 packets_taken, bytes_checked);
        $display("with %0d register writes and four register settings", config_writes);
        if (error_count == 0)
            $display("servo_sync_write_framer test passed");
        else
            $display("servo_sync_write_framer test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("servo_sync_write_framer test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ssw_pkg.sv
rtl/ssw_if.sv
rtl/servo_sync_write_framer.sv
tb/sv/testbench.sv
